### rtl/ovnh_pkg.sv
`timescale 1ns / 1ps
// Package for the octave value noise height block: register indexes,
// hash constants, the lane configuration struct and the cosine weight function.
// No dependencies.
package ovnh_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_NOISE_ENABLE = 3'd0;
    localparam logic [2:0] REG_NOISE_SEED   = 3'd1;
    localparam logic [2:0] REG_OCTAVE_COUNT = 3'd2;
    localparam logic [2:0] REG_INV_WAVELEN  = 3'd3;
    localparam logic [2:0] REG_OCTAVE_GAINS = 3'd4;
    localparam logic [2:0] REG_COMMON_AMP   = 3'd5;
    localparam logic [2:0] REG_TWIST_AMP    = 3'd6;

    localparam logic [31:0] FMIX_C1     = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2     = 32'hc2b2ae35;
    localparam logic [31:0] SALT_MUL    = 32'h9e3779b9;
    localparam logic [31:0] CHAN_EVEN   = 32'h165667b1;
    localparam logic [31:0] CHAN_ODD    = 32'h27d4eb2f;
    localparam logic [15:0] INV_WL_MAX  = 16'd40960;

    localparam logic [63:0] SIN_A1 = 64'd1686629713;
    localparam logic [63:0] SIN_A3 = 64'd693598668;
    localparam logic [63:0] SIN_A5 = 64'd85569306;
    localparam logic [63:0] SIN_A7 = 64'd5026995;
    localparam logic [63:0] SIN_A9 = 64'd172272;

    // Register stages inside one octave lane, then the sum and the output stage.
    localparam int LANE_STAGES = 9;
    localparam int PIPE_STAGES = LANE_STAGES + 2;

    localparam int TERM_W = 51;
    localparam int ACC_W  = 53;

    // Per-lane settings derived from the configuration registers.
    typedef struct packed {
        logic [15:0] inv;
        logic [31:0] gain_amp;
    } lane_cfg_t;

    // Precomputed salts: even channel and the two side-dependent odd channels.
    typedef struct packed {
        logic [31:0] even;
        logic [31:0] odd0;
        logic [31:0] odd1;
    } chan_salt_t;

    // Raised-cosine weight in Q16 for table entry k; used only on constants.
    function automatic logic [16:0] cos_weight(input int unsigned k, input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] w;
        x  = 64'(k) << (30 - bits);
        x2 = (x * x) >> 30;
        p  = SIN_A9;
        p  = SIN_A7 - ((p * x2) >> 30);
        p  = SIN_A5 - ((p * x2) >> 30);
        p  = SIN_A3 - ((p * x2) >> 30);
        p  = SIN_A1 - ((p * x2) >> 30);
        s  = (p * x) >> 30;
        w  = (s * s) >> 30;
        if (w > (64'd1 << 30))
        begin
            w = 64'd1 << 30;
        end
        return w[30:14];
    endfunction

endpackage

### rtl/octave_value_noise_height_top.sv
`timescale 1ns / 1ps
// Top level of the octave value noise height block: configuration registers,
// octave lanes, summation and output rounding. Depends on ovnh_pkg and ovnh_lane.

// The block accepts one coordinate transaction per clock while the output is not
// stalled and returns one height per transaction through nine register stages in each
// octave lane (scaling multiply, lattice index and table lookup, four finalizer
// multiplies, blend products, blend offset and weighting multiply), one stage for the
// octave sum and one for rounding and saturation. All octaves run in parallel lanes,
// so throughput stays one per cycle whatever the octave count. A held output stall
// freezes the whole pipeline.
// The user must write configuration only while no transaction is in flight; the block
// does not enforce this. A write takes effect once the derived settings are registered.
module octave_value_noise_height_top
    import ovnh_pkg::*;
#(
    parameter int MAX_OCTAVES    = 4,
    parameter int COS_TABLE_BITS = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        track_pos,
    input  logic               rail_side,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [20:0] height_noise
);

    localparam int CNT_W = 3;

    logic        noise_enable_reg;
    logic [31:0] noise_seed_reg;
    logic [2:0]  octave_count_reg;
    logic [63:0] inv_wl_reg;
    logic [63:0] gains_reg;
    logic [15:0] common_amp_reg;
    logic [15:0] twist_amp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_enable_reg <= 1'b0;
            noise_seed_reg   <= '0;
            octave_count_reg <= '0;
            inv_wl_reg       <= '0;
            gains_reg        <= '0;
            common_amp_reg   <= '0;
            twist_amp_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_NOISE_ENABLE: noise_enable_reg <= cfg_data[0];
                REG_NOISE_SEED:   noise_seed_reg   <= cfg_data[31:0];
                REG_OCTAVE_COUNT: octave_count_reg <= cfg_data[2:0];
                REG_INV_WAVELEN:  inv_wl_reg       <= cfg_data;
                REG_OCTAVE_GAINS: gains_reg        <= cfg_data;
                REG_COMMON_AMP:   common_amp_reg   <= cfg_data[15:0];
                REG_TWIST_AMP:    twist_amp_reg    <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // Values derived from configuration, registered anew on every clock.
    lane_cfg_t             lane_cfg_reg [MAX_OCTAVES];
    chan_salt_t            salts_reg;
    logic [MAX_OCTAVES-1:0] active_reg;
    logic [CNT_W-1:0]      n_eff;

    assign n_eff = (octave_count_reg > CNT_W'(MAX_OCTAVES)) ? CNT_W'(MAX_OCTAVES)
                                                          : octave_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            salts_reg  <= '0;
            active_reg <= '0;
            for (int i = 0; i < MAX_OCTAVES; i++)
            begin
                lane_cfg_reg[i] <= '0;
            end
        end
        else
        begin
            salts_reg.even <= 32'((noise_seed_reg ^ CHAN_EVEN) * SALT_MUL);
            salts_reg.odd0 <= 32'((noise_seed_reg ^ CHAN_ODD) * SALT_MUL);
            salts_reg.odd1 <= 32'((noise_seed_reg ^ 32'(CHAN_ODD << 1)) * SALT_MUL);
            for (int i = 0; i < MAX_OCTAVES; i++)
            begin
                active_reg[i] <= noise_enable_reg && (CNT_W'(i) < n_eff);
                lane_cfg_reg[i].inv <= (inv_wl_reg[16*i +: 16] > INV_WL_MAX) ? INV_WL_MAX
                                                                             : inv_wl_reg[16*i +: 16];
                lane_cfg_reg[i].gain_amp <= gains_reg[16*i +: 16]
                                            * ((i % 2 == 0) ? common_amp_reg : twist_amp_reg);
            end
        end
    end

    // The whole pipeline moves unless a finished result is held by the consumer.
    logic                   adv;
    logic [PIPE_STAGES-1:0] valid_reg;

    assign adv      = !(valid_reg[PIPE_STAGES-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[PIPE_STAGES-2:0], in_valid};
        end
    end

    logic signed [TERM_W-1:0] terms [MAX_OCTAVES];

    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_lane
        ovnh_lane #(
            .COS_TABLE_BITS (COS_TABLE_BITS),
            .LANE_ODD       ((i % 2) == 1)
        ) u_lane (
            .clk        (clk),
            .adv        (adv),
            .track_pos  (track_pos),
            .rail_side  (rail_side),
            .lane_cfg   (lane_cfg_reg[i]),
            .salts      (salts_reg),
            .term       (terms[i])
        );
    end

    logic signed [ACC_W-1:0] acc_next, acc_reg, biased;
    logic signed [ACC_W-32:0] quot;
    logic signed [20:0]      res_next, res_reg;

    always_comb
    begin
        acc_next = '0;
        for (int i = 0; i < MAX_OCTAVES; i++)
        begin
            if (active_reg[i])
            begin
                acc_next = acc_next + ACC_W'(terms[i]);
            end
        end
    end

    // Round half up, then saturate to the 21-bit output range.
    assign biased = acc_reg + (ACC_W'(1) <<< 30);
    assign quot   = biased[ACC_W-1:31];

    always_comb
    begin
        if (quot > (ACC_W-31)'(1048575))
        begin
            res_next = 21'sd1048575;
        end
        else if (quot < -(ACC_W-31)'(1048576))
        begin
            res_next = -21'sd1048576;
        end
        else
        begin
            res_next = quot[20:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg <= acc_next;
            res_reg <= res_next;
        end
    end

    assign out_valid    = valid_reg[PIPE_STAGES-1];
    assign height_noise = res_reg;

`ifndef SYNTH
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(valid_reg))
        else $error("pipeline moved while the output was stalled");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");
`endif

endmodule

### rtl/ovnh_lane.sv
`timescale 1ns / 1ps
// One octave lane: lattice scaling, two seeded finalizer hashes, cosine blend
// and the weighted term. Depends on ovnh_pkg.
module ovnh_lane
    import ovnh_pkg::*;
#(
    parameter int COS_TABLE_BITS = 10,
    parameter bit LANE_ODD = 1'b0
)
(
    input  logic                     clk,
    input  logic                     adv,
    input  logic [31:0]              track_pos,
    input  logic                     rail_side,
    input  lane_cfg_t                lane_cfg,
    input  chan_salt_t               salts,
    output logic signed [TERM_W-1:0] term
);

    localparam int K_W = COS_TABLE_BITS;

    logic [16:0] cos_rom [2**K_W];

    for (genvar g = 0; g < 2**K_W; g++)
    begin : g_rom
        assign cos_rom[g] = cos_weight(g, K_W);
    end

    // Stage 1: coordinate times inverse wavelength.
    logic [47:0]    t_next;
    logic [31:0]    ix_reg;
    logic [K_W-1:0] k_reg;
    logic           side1_reg;

    assign t_next = track_pos * lane_cfg.inv;

    // Stage 2: both lattice indexes and the blend weight.
    logic [31:0] ix0_reg, ix1_reg;
    logic [16:0] w2_reg;
    logic        side2_reg;

    // Stages 3 to 6: finalizer multiplies.
    logic [31:0] h3a_reg, h3b_reg, h4a_reg, h4b_reg, h5a_reg, h5b_reg, h6a_reg, h6b_reg;
    logic [16:0] w3_reg, w4_reg, w5_reg, w6_reg;
    logic        side3_reg, side4_reg;
    logic [31:0] salt;
    logic [31:0] x3a, x3b, x4a, x4b, g5a, g5b, x5a, x5b, x6a, x6b, n0, n1;

    assign x3a = ix0_reg ^ (ix0_reg >> 16);
    assign x3b = ix1_reg ^ (ix1_reg >> 16);
    assign x4a = h3a_reg ^ (h3a_reg >> 13);
    assign x4b = h3b_reg ^ (h3b_reg >> 13);

    if (LANE_ODD)
    begin : g_odd
        assign salt = side4_reg ? salts.odd1 : salts.odd0;
    end
    else
    begin : g_even
        assign salt = salts.even;
    end

    assign g5a = h4a_reg ^ (h4a_reg >> 16) ^ salt;
    assign g5b = h4b_reg ^ (h4b_reg >> 16) ^ salt;
    assign x5a = g5a ^ (g5a >> 16);
    assign x5b = g5b ^ (g5b >> 16);
    assign x6a = h5a_reg ^ (h5a_reg >> 13);
    assign x6b = h5b_reg ^ (h5b_reg >> 13);
    assign n0  = h6a_reg ^ (h6a_reg >> 16);
    assign n1  = h6b_reg ^ (h6b_reg >> 16);

    // Stage 7: weighted node products; stage 8: blend offset to the range [-131072, -1].
    logic [48:0]        p0_reg, p1_reg;
    logic [48:0]        v_sum;
    logic signed [17:0] o_reg;
    logic [16:0]        w_inv;

    assign w_inv = 17'd65536 - w6_reg;
    assign v_sum = p0_reg + p1_reg;

    // Stage 9: term = gain * amplitude * blend.
    logic signed [TERM_W-1:0] term_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ix_reg    <= {4'd0, t_next[47:20]};
            k_reg     <= t_next[19 -: K_W];
            side1_reg <= rail_side;

            ix0_reg   <= ix_reg;
            ix1_reg   <= ix_reg + 32'd1;
            w2_reg    <= cos_rom[k_reg];
            side2_reg <= side1_reg;

            h3a_reg   <= 32'(x3a * FMIX_C1);
            h3b_reg   <= 32'(x3b * FMIX_C1);
            w3_reg    <= w2_reg;
            side3_reg <= side2_reg;

            h4a_reg   <= 32'(x4a * FMIX_C2);
            h4b_reg   <= 32'(x4b * FMIX_C2);
            w4_reg    <= w3_reg;
            side4_reg <= side3_reg;

            h5a_reg   <= 32'(x5a * FMIX_C1);
            h5b_reg   <= 32'(x5b * FMIX_C1);
            w5_reg    <= w4_reg;

            h6a_reg   <= 32'(x6a * FMIX_C2);
            h6b_reg   <= 32'(x6b * FMIX_C2);
            w6_reg    <= w5_reg;

            p0_reg    <= 49'(n0 * w_inv);
            p1_reg    <= 49'(n1 * w6_reg);

            o_reg     <= $signed({1'b0, v_sum[47:31]}) - 18'sd131072;

            term_reg  <= TERM_W'($signed({1'b0, lane_cfg.gain_amp}) * o_reg);
        end
    end

    assign term = term_reg;

endmodule

### dv/octave_value_noise_height_top_tb.sv
`timescale 1ns / 1ps
// Testbench for octave_value_noise_height_top: random and directed coordinates
// checked against a built-in height predictor. Depends on ovnh_pkg and the RTL.
module octave_value_noise_height_top_tb;
    import ovnh_pkg::*;

    localparam int TABLE_BITS = 10;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [2:0] REG_BEYOND_LIST = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        track_pos;
    logic               rail_side;
    logic               out_valid;
    logic               out_stall;
    logic signed [20:0] height_noise;

    octave_value_noise_height_top u_top (.*);

    // Predictor copy of the registers.
    logic        m_enable;
    logic [31:0] m_seed;
    logic [2:0]  m_count;
    logic [63:0] m_inv;
    logic [63:0] m_gain;
    logic [15:0] m_common;
    logic [15:0] m_twist;

    function automatic logic [31:0] fmix(input logic [31:0] v);
        v = v ^ (v >> 16);
        v = v * FMIX_C1;
        v = v ^ (v >> 13);
        v = v * FMIX_C2;
        v = v ^ (v >> 16);
        return v;
    endfunction

    function automatic logic [31:0] node_hash(input logic [31:0] ix, input logic [31:0] chan);
        logic [31:0] salt;
        salt = chan * SALT_MUL;
        return fmix(fmix(ix) ^ salt);
    endfunction

    function automatic logic [16:0] blend_weight(input logic [31:0] k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] w;
        x  = 64'(k) << (30 - TABLE_BITS);
        x2 = (x * x) >> 30;
        p  = 64'd172272;
        p  = 64'd5026995 - ((p * x2) >> 30);
        p  = 64'd85569306 - ((p * x2) >> 30);
        p  = 64'd693598668 - ((p * x2) >> 30);
        p  = 64'd1686629713 - ((p * x2) >> 30);
        s  = (p * x) >> 30;
        w  = (s * s) >> 30;
        if (w > (64'd1 << 30))
        begin
            w = 64'd1 << 30;
        end
        return w[30:14];
    endfunction

    function automatic logic signed [20:0] predict_height(input logic [31:0] coord,
                                                          input logic side);
        logic signed [63:0] acc;
        logic signed [63:0] res;
        logic signed [63:0] o;
        logic [63:0] inv;
        logic [63:0] gain;
        logic [63:0] t;
        logic [63:0] v;
        logic [31:0] ix;
        logic [31:0] chan;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [16:0] w;
        logic [15:0] amp;
        int n;
        acc = 0;
        n = m_count;
        if (!m_enable || n == 0)
        begin
            return '0;
        end
        if (n > 4)
        begin
            n = 4;
        end
        for (int i = 0; i < n; i++)
        begin
            inv  = (m_inv >> (16 * i)) & 64'hffff;
            gain = (m_gain >> (16 * i)) & 64'hffff;
            if (inv > 64'd40960)
            begin
                inv = 64'd40960;
            end
            t  = 64'(coord) * inv;
            ix = t[51:20];
            w  = blend_weight(32'(t[19:0] >> (20 - TABLE_BITS)));
            if (i % 2 == 0)
            begin
                chan = m_seed ^ CHAN_EVEN;
                amp  = m_common;
            end
            else
            begin
                chan = m_seed ^ (side ? (CHAN_ODD * 32'd2) : CHAN_ODD);
                amp  = m_twist;
            end
            n0 = node_hash(ix, chan);
            n1 = node_hash(ix + 32'd1, chan);
            v  = 64'(n0) * (64'd65536 - 64'(w)) + 64'(n1) * 64'(w);
            o  = $signed(v >> 31) - 64'sd131072;
            acc += $signed(gain * 64'(amp)) * o;
        end
        res = (acc + (64'sd1 << 30)) >>> 31;
        if (res > 64'sd1048575)
        begin
            res = 64'sd1048575;
        end
        if (res < -64'sd1048576)
        begin
            res = -64'sd1048576;
        end
        return res[20:0];
    endfunction

    class height_scoreboard;
        logic signed [20:0] pending_heights[$];
        int errors = 0;

        function void note_query(logic signed [20:0] h);
            pending_heights = {pending_heights, h};
        endfunction

        function void check_height(logic signed [20:0] got);
            logic signed [20:0] want;
            if (pending_heights.size() == 0)
            begin
                $display("%0t: unexpected height, expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = pending_heights.pop_front();
            if (got !== want)
            begin
                $display("%0t: height mismatch, expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    height_scoreboard sb;
    int  cycle_count;
    bit  hold_off;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: random stalls, and one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : ($urandom_range(0, 1) == 1);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_height(height_noise);
        end
    end

    // One write, then a wait for the derived settings to be registered before traffic.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_NOISE_ENABLE: m_enable = val[0];
            REG_NOISE_SEED:   m_seed   = val[31:0];
            REG_OCTAVE_COUNT: m_count  = val[2:0];
            REG_INV_WAVELEN:  m_inv    = val;
            REG_OCTAVE_GAINS: m_gain   = val;
            REG_COMMON_AMP:   m_common = val[15:0];
            REG_TWIST_AMP:    m_twist  = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending_heights.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    // Sends one query; valid stays high across back-to-back transactions.
    task automatic send_query(input logic [31:0] coord, input logic side, input bit gaps);
        int gap;
        in_valid  <= 1'b1;
        track_pos <= coord;
        rail_side <= side;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_query(predict_height(coord, side));
        gap = 0;
        if (gaps && $urandom_range(0, 2) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_inv4();
        logic [63:0] r;
        r = rand64();
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(0, 4))
                0: r[16 * i +: 16] = 16'd0;
                1: r[16 * i +: 16] = 16'hffff;
                2: r[16 * i +: 16] = 16'd40960;
                default: r[16 * i +: 16] = 16'($urandom_range(0, 40960));
            endcase
        end
        return r;
    endfunction

    task automatic random_config(input bit extremes);
        write_reg(REG_NOISE_ENABLE, 64'($urandom_range(0, 5) != 0));
        write_reg(REG_NOISE_SEED, 64'($urandom));
        write_reg(REG_OCTAVE_COUNT, 64'($urandom_range(0, 7)));
        write_reg(REG_INV_WAVELEN, rand_inv4());
        write_reg(REG_OCTAVE_GAINS, extremes ? 64'hffff_ffff_ffff_ffff : rand64());
        write_reg(REG_COMMON_AMP, extremes ? 64'hffff : 64'($urandom_range(0, 65535)));
        write_reg(REG_TWIST_AMP, extremes ? 64'hffff : 64'($urandom_range(0, 65535)));
        // Out-of-range index must be ignored.
        write_reg(REG_BEYOND_LIST, rand64());
    endtask

    initial
    begin
        sb = new();
        hold_off = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        track_pos = '0;
        rail_side = 1'b0;
        m_enable = 0; m_seed = 0; m_count = 0; m_inv = 0; m_gain = 0;
        m_common = 0; m_twist = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Reset state: noise disabled.
        send_query(32'h1234_5678, 1'b0, 1'b0);
        stop_sending();
        drain();

        // Directed: equal gains, four octaves, extreme coordinates and both sides.
        write_reg(REG_NOISE_ENABLE, 64'd1);
        write_reg(REG_NOISE_SEED, 64'hdead_beef);
        write_reg(REG_OCTAVE_COUNT, 64'd4);
        write_reg(REG_INV_WAVELEN, {16'hffff, 16'd40960, 16'd0, 16'd4096});
        write_reg(REG_OCTAVE_GAINS, {4{16'h4000}});
        write_reg(REG_COMMON_AMP, 64'd65535);
        write_reg(REG_TWIST_AMP, 64'd65535);
        send_query(32'h0, 1'b0, 1'b0);
        send_query(32'hffff_ffff, 1'b1, 1'b0);
        send_query(32'hffff_ffff, 1'b0, 1'b0);
        send_query(32'h8000_0080, 1'b1, 1'b0);
        send_query(32'h0000_0001, 1'b0, 1'b0);
        stop_sending();
        drain();
        // Zero gains give nothing; count above four acts as four; then all gains at maximum.
        write_reg(REG_OCTAVE_COUNT, 64'd7);
        write_reg(REG_OCTAVE_GAINS, 64'd0);
        send_query(32'h5555_5555, 1'b1, 1'b0);
        stop_sending();
        drain();
        write_reg(REG_OCTAVE_GAINS, 64'hffff_ffff_ffff_ffff);
        for (int i = 0; i < 6; i++)
        begin
            send_query($urandom, i[0], 1'b0);
        end
        stop_sending();
        drain();
        write_reg(REG_OCTAVE_COUNT, 64'd0);
        send_query(32'haaaa_aaaa, 1'b1, 1'b0);
        stop_sending();
        drain();

        // Random phases, with one long receiver hold-off in the first.
        for (int ph = 0; ph < 9; ph++)
        begin
            random_config(ph == 3);
            if (ph == 0)
            begin
                hold_off = 1'b1;
            end
            for (int i = 0; i < 50; i++)
            begin
                send_query($urandom, $urandom_range(0, 1), ph != 0);
            end
            stop_sending();
            drain();
        end

        if (sb.errors == 0 && sb.pending_heights.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/ovnh_pkg.sv
rtl/ovnh_lane.sv
rtl/octave_value_noise_height_top.sv
dv/octave_value_noise_height_top_tb.sv
